@@ src/adsr_envelope_shaper_assert.svh @@
// Assertion macros shared by the checker of the envelope shaper.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ADSR_ENVELOPE_SHAPER_ASSERT_SVH
`define ADSR_ENVELOPE_SHAPER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ADSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/adsr_pkg.sv @@
package adsr_pkg;

  localparam int unsigned LevelBits    = 34;  // Q4.30 envelope level
  localparam int unsigned LevelFrac    = 30;
  localparam int unsigned LevelWhole   = LevelBits - LevelFrac;
  localparam int unsigned StepBits     = 32;
  localparam int unsigned GainBits     = 16;  // Q2.14 levels
  localparam int unsigned DividendBits = GainBits + 16;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned PhaseBits    = 2;

  typedef logic [CfgIndexBits-1:0] cfg_index_t;

  localparam cfg_index_t RegAttackSamples  = 3'd0;
  localparam cfg_index_t RegDecaySamples   = 3'd1;
  localparam cfg_index_t RegReleaseSamples = 3'd2;
  localparam cfg_index_t RegTotalSamples   = 3'd3;
  localparam cfg_index_t RegAttackLevel    = 3'd4;
  localparam cfg_index_t RegSustainLevel   = 3'd5;

  localparam logic [GainBits-1:0] GainResetValue = 16'd16384;

  typedef enum logic [PhaseBits-1:0] {
    PhaseAttack  = 2'd0,
    PhaseDecay   = 2'd1,
    PhaseSustain = 2'd2,
    PhaseRelease = 2'd3
  } phase_e;

  // Per-phase level steps, recomputed after every register write.
  typedef struct packed {
    logic [StepBits-1:0] attack_step;
    logic [StepBits-1:0] decay_step;   // magnitude
    logic                decay_neg;    // level rises during decay
    logic [StepBits-1:0] release_step;
  } step_t;

endpackage

@@ src/adsr_div.sv @@
module adsr_div #(
  parameter int unsigned DIVISOR_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [adsr_pkg::DividendBits-1:0]      dividend_i,
  input  logic [DIVISOR_BITS-1:0]                divisor_i,
  output logic                                   done_o,
  output logic [adsr_pkg::DividendBits-1:0]      quotient_o
);

  localparam int unsigned DvdBits = adsr_pkg::DividendBits;
  localparam int unsigned CntBits = $clog2(DvdBits);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(DvdBits - 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_BITS-1:0] rem_q, rem_d;
  logic [DIVISOR_BITS-1:0] div_q, div_d;
  logic [DvdBits-1:0]      dvd_q, dvd_d;
  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS:0]   trial;
  logic                    fits;

  // One quotient bit per cycle, restoring.
  assign shifted = {rem_q, dvd_q[DvdBits-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      dvd_d = {dvd_q[DvdBits-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    dvd_q <= dvd_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ src/adsr_cfg.sv @@
module adsr_cfg #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adsr_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [adsr_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic [COUNT_BITS-1:0]               attack_samples_o,
  output logic [COUNT_BITS-1:0]               decay_samples_o,
  output logic [COUNT_BITS-1:0]               release_samples_o,
  output logic [COUNT_BITS-1:0]               total_samples_o,
  output adsr_pkg::step_t                     steps_o
);

  localparam int unsigned GainW = adsr_pkg::GainBits;
  localparam int unsigned DvdW  = adsr_pkg::DividendBits;
  localparam int unsigned StepW = adsr_pkg::StepBits;

  typedef enum logic [3:0] {
    SeqIdle    = 4'b0001,
    SeqAttack  = 4'b0010,
    SeqDecay   = 4'b0100,
    SeqRelease = 4'b1000
  } seq_e;

  seq_e                 state_q, state_d;
  logic                 launch_q, launch_d;
  logic [COUNT_BITS-1:0] attack_q, decay_q, release_q, total_q;
  logic [GainW-1:0]      atk_level_q, sus_level_q;
  adsr_pkg::step_t       steps_q;
  logic                  cfg_fire;
  logic [GainW:0]        diff;
  logic                  diff_neg;
  logic [GainW-1:0]      diff_mag;
  logic [DvdW-1:0]       dividend;
  logic [COUNT_BITS-1:0] divisor;
  logic                  div_done;
  logic [DvdW-1:0]       quotient;
  logic [StepW-1:0]      step_res;

  assign cfg_ready_o = (state_q == SeqIdle);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Signed level difference for the decay step, split into sign and magnitude.
  assign diff     = {1'b0, atk_level_q} - {1'b0, sus_level_q};
  assign diff_neg = diff[GainW];
  assign diff_mag = diff_neg ? GainW'(-diff) : diff[GainW-1:0];

  always_comb begin
    case (state_q)
      SeqAttack: begin
        dividend = {atk_level_q, 16'd0};
        divisor  = attack_q;
      end
      SeqDecay: begin
        dividend = {diff_mag, 16'd0};
        divisor  = decay_q;
      end
      SeqRelease: begin
        dividend = {sus_level_q, 16'd0};
        divisor  = release_q;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  adsr_div #(
    .DIVISOR_BITS(COUNT_BITS)
  ) u_adsr_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (launch_q),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // A zero-length phase has a zero step.
  assign step_res = (divisor == '0) ? '0 : StepW'(quotient);

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    case (state_q)
      SeqIdle: begin
        if (cfg_fire) begin
          state_d  = SeqAttack;
          launch_d = 1'b1;
        end
      end
      SeqAttack: begin
        if (div_done) begin
          state_d  = SeqDecay;
          launch_d = 1'b1;
        end
      end
      SeqDecay: begin
        if (div_done) begin
          state_d  = SeqRelease;
          launch_d = 1'b1;
        end
      end
      SeqRelease: begin
        if (div_done) begin
          state_d = SeqIdle;
        end
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      launch_q    <= 1'b0;
      attack_q    <= '0;
      decay_q     <= '0;
      release_q   <= '0;
      total_q     <= COUNT_BITS'(1);
      atk_level_q <= adsr_pkg::GainResetValue;
      sus_level_q <= adsr_pkg::GainResetValue;
      steps_q     <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          adsr_pkg::RegAttackSamples:  attack_q    <= cfg_data_i[COUNT_BITS-1:0];
          adsr_pkg::RegDecaySamples:   decay_q     <= cfg_data_i[COUNT_BITS-1:0];
          adsr_pkg::RegReleaseSamples: release_q   <= cfg_data_i[COUNT_BITS-1:0];
          adsr_pkg::RegTotalSamples:   total_q     <= cfg_data_i[COUNT_BITS-1:0];
          adsr_pkg::RegAttackLevel:    atk_level_q <= cfg_data_i[GainW-1:0];
          adsr_pkg::RegSustainLevel:   sus_level_q <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (div_done) begin
        case (state_q)
          SeqAttack: steps_q.attack_step <= step_res;
          SeqDecay: begin
            steps_q.decay_step <= step_res;
            steps_q.decay_neg  <= diff_neg;
          end
          SeqRelease: steps_q.release_step <= step_res;
          default: ;
        endcase
      end
    end
  end

  assign attack_samples_o  = attack_q;
  assign decay_samples_o   = decay_q;
  assign release_samples_o = release_q;
  assign total_samples_o   = total_q;
  assign steps_o           = steps_q;

endmodule

@@ src/adsr_front.sv @@
module adsr_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20,
  parameter int unsigned ENTRY_BITS  = SAMPLE_BITS + adsr_pkg::LevelBits
                                       + adsr_pkg::PhaseBits + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    enable_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  logic [COUNT_BITS-1:0]   attack_samples_i,
  input  logic [COUNT_BITS-1:0]   decay_samples_i,
  input  logic [COUNT_BITS-1:0]   release_samples_i,
  input  logic [COUNT_BITS-1:0]   total_samples_i,
  input  adsr_pkg::step_t         steps_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output logic [ENTRY_BITS-1:0]   entry_o
);

  localparam int unsigned LvlW  = adsr_pkg::LevelBits;

  logic [COUNT_BITS-1:0] index_q, index_d;
  logic [LvlW-1:0]       level_q, level_d;
  logic [COUNT_BITS-1:0] n_len;
  logic [COUNT_BITS:0]   ad_sum;
  logic [COUNT_BITS:0]   ir_sum;
  logic                  last;
  adsr_pkg::phase_e      phase;
  logic [LvlW:0]         atk_sum, dec_sum;
  logic [LvlW-1:0]       atk_next, dec_up, dec_down, rel_down;
  logic [LvlW-1:0]       atk_ext, dec_ext, rel_ext;
  logic [LvlW-1:0]       level_next;

  assign in_ready_o = enable_i && !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // A total length of zero acts as one.
  assign n_len  = (total_samples_i == '0) ? COUNT_BITS'(1) : total_samples_i;
  assign ad_sum = {1'b0, attack_samples_i} + {1'b0, decay_samples_i};
  assign ir_sum = {1'b0, index_q} + {1'b0, release_samples_i};
  assign last   = index_q >= (n_len - COUNT_BITS'(1));

  assign atk_ext = LvlW'(steps_i.attack_step);
  assign dec_ext = LvlW'(steps_i.decay_step);
  assign rel_ext = LvlW'(steps_i.release_step);

  // Saturate at full scale going up, at zero going down.
  assign atk_sum  = {1'b0, level_q} + {1'b0, atk_ext};
  assign atk_next = atk_sum[LvlW] ? '1 : atk_sum[LvlW-1:0];
  assign dec_sum  = {1'b0, level_q} + {1'b0, dec_ext};
  assign dec_up   = dec_sum[LvlW] ? '1 : dec_sum[LvlW-1:0];
  assign dec_down = (level_q > dec_ext) ? level_q - dec_ext : '0;
  assign rel_down = (level_q > rel_ext) ? level_q - rel_ext : '0;

  always_comb begin
    if (index_q < attack_samples_i) begin
      phase      = adsr_pkg::PhaseAttack;
      level_next = atk_next;
    end else if ({1'b0, index_q} < ad_sum) begin
      phase      = adsr_pkg::PhaseDecay;
      level_next = steps_i.decay_neg ? dec_up : dec_down;
    end else if (ir_sum < {1'b0, n_len}) begin
      phase      = adsr_pkg::PhaseSustain;
      level_next = level_q;
    end else begin
      phase      = adsr_pkg::PhaseRelease;
      level_next = rel_down;
    end
  end

  // Start the next sound from zero after the last sample.
  assign index_d = last ? '0 : index_q + COUNT_BITS'(1);
  assign level_d = last ? '0 : level_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      level_q <= '0;
    end else if (push_o) begin
      index_q <= index_d;
      level_q <= level_d;
    end
  end

  // The sample is scaled by the level held before this sample's update.
  assign entry_o = {last, phase, level_q, sample_i};

endmodule

@@ src/adsr_fifo.sv @@
module adsr_fifo #(
  parameter int unsigned WIDTH = 53,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/adsr_back.sv @@
module adsr_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ENTRY_BITS  = SAMPLE_BITS + adsr_pkg::LevelBits
                                       + adsr_pkg::PhaseBits + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          entry_valid_i,
  input  logic [ENTRY_BITS-1:0]         entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS-1:0]        sample_o,
  output logic [adsr_pkg::PhaseBits-1:0] phase_o,
  output logic                          last_o
);

  localparam int unsigned LvlW  = adsr_pkg::LevelBits;
  localparam int unsigned FracW = adsr_pkg::LevelFrac;
  localparam int unsigned WholW = adsr_pkg::LevelWhole;
  localparam int unsigned PhW   = adsr_pkg::PhaseBits;
  localparam int unsigned LoW   = SAMPLE_BITS + FracW;
  localparam int unsigned HiW   = SAMPLE_BITS + WholW;
  localparam int unsigned ResW  = SAMPLE_BITS + 5;
  localparam logic [LoW:0]    RoundHalf = (LoW + 1)'(1) << (FracW - 1);
  localparam logic [ResW-1:0] HalfScale = ResW'(1) << (SAMPLE_BITS - 1);

  logic [SAMPLE_BITS-1:0] raw;
  logic [LvlW-1:0]        lvl;
  logic [PhW-1:0]         ph;
  logic                   lst;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   out_adv, s1_adv;

  logic                   s1_valid_q;
  logic [LoW-1:0]         plo_q;
  logic [HiW-1:0]         phi_q;
  logic                   neg_q;
  logic [PhW-1:0]         s1_phase_q;
  logic                   s1_last_q;

  logic [LoW:0]           rnd_sum;
  logic [ResW-1:0]        res;
  logic [ResW-1:0]        mag_sat;
  logic [SAMPLE_BITS-1:0] sample_d;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic [PhW-1:0]         out_phase_q;
  logic                   out_last_q;

  assign raw = entry_i[SAMPLE_BITS-1:0];
  assign lvl = entry_i[SAMPLE_BITS +: LvlW];
  assign ph  = entry_i[SAMPLE_BITS + LvlW +: PhW];
  assign lst = entry_i[SAMPLE_BITS + LvlW + PhW];

  // Advance each stage when the one after it is free or moving.
  assign out_adv = !out_valid_q || out_ready_i;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign pop_o   = entry_valid_i && s1_adv;

  assign neg = raw[SAMPLE_BITS-1];
  assign mag = neg ? (~raw + 1'b1) : raw;

  // Stage one: magnitude times fractional and whole parts of the level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      plo_q      <= LoW'(mag) * LoW'(lvl[FracW-1:0]);
      phi_q      <= HiW'(mag) * HiW'(lvl[LvlW-1:FracW]);
      neg_q      <= neg;
      s1_phase_q <= ph;
      s1_last_q  <= lst;
    end
  end

  // Stage two: round half away from zero on the magnitude, then saturate.
  assign rnd_sum = {1'b0, plo_q} + RoundHalf;
  assign res     = ResW'(phi_q) + ResW'(rnd_sum[LoW:FracW]);

  always_comb begin
    if (neg_q) begin
      mag_sat  = (res > HalfScale) ? HalfScale : res;
      sample_d = ~mag_sat[SAMPLE_BITS-1:0] + 1'b1;
    end else begin
      mag_sat  = (res > HalfScale - 1'b1) ? HalfScale - 1'b1 : res;
      sample_d = mag_sat[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_sample_q <= sample_d;
      out_phase_q  <= s1_phase_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign phase_o     = out_phase_q;
  assign last_o      = out_last_q;

endmodule

@@ src/adsr_envelope_shaper.sv @@
// Linear ADSR envelope shaper for a stream of signed audio samples.
// Channels: a configuration write channel (cfg_valid_i/cfg_ready_o with a register
// index and data), a sample input stream (s_axis_*) and a result stream (m_axis_*).
// Result tdata carries the scaled sample, tuser the envelope phase (0 attack,
// 1 decay, 2 sustain, 3 release) and tlast marks the final sample of a sound.
// Throughput: one sample per clock cycle while no step recompute runs and the
// output is not stalled. A result passes through the queue, the multiply stage
// and the result register. After every register write a shared restoring divider
// recomputes the three phase steps one quotient bit per cycle, three divisions in
// a row; during that time cfg_ready_o and s_axis_tready stay low.
// Reset: all registers take their reset values, the steps are zero, the sample
// index and level of the sound are zero, and all queues are empty.
// Stall: when m_axis_tready is low the result register holds, the multiply stage
// and a four-entry queue fill up, and s_axis_tready drops only once the queue
// is full; no result is ever lost or repeated.
module adsr_envelope_shaper #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adsr_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [adsr_pkg::CfgDataBits-1:0]    cfg_data_i,
  // sample input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
  output logic [adsr_pkg::PhaseBits-1:0]      m_axis_tuser,   // [1:0] phase
  output logic                                m_axis_tlast    // last_of_sound
);

  localparam int unsigned TdataBits  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned EntryBits  = SAMPLE_BITS + adsr_pkg::LevelBits
                                       + adsr_pkg::PhaseBits + 1;
  localparam int unsigned QueueDepth = 4;

  logic [COUNT_BITS-1:0] attack_samples, decay_samples;
  logic [COUNT_BITS-1:0] release_samples, total_samples;
  adsr_pkg::step_t       steps;
  logic                  cfg_idle;
  logic                  push, queue_full;
  logic [EntryBits-1:0]  push_entry;
  logic                  queue_valid, pop;
  logic [EntryBits-1:0]  pop_entry;
  logic [SAMPLE_BITS-1:0] sample_out;

  // Hold the register file and recompute the steps after each write.
  adsr_cfg #(
    .COUNT_BITS(COUNT_BITS)
  ) u_adsr_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_idle),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .attack_samples_o (attack_samples),
    .decay_samples_o  (decay_samples),
    .release_samples_o(release_samples),
    .total_samples_o  (total_samples),
    .steps_o          (steps)
  );

  assign cfg_ready_o = cfg_idle;

  // Front: classify the phase, advance index and level, queue the work.
  adsr_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_adsr_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .enable_i         (cfg_idle),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .sample_i         (s_axis_tdata[SAMPLE_BITS-1:0]),
    .attack_samples_i (attack_samples),
    .decay_samples_i  (decay_samples),
    .release_samples_i(release_samples),
    .total_samples_i  (total_samples),
    .steps_i          (steps),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  // Short queue so front and back can stall independently.
  adsr_fifo #(
    .WIDTH(EntryBits),
    .DEPTH(QueueDepth)
  ) u_adsr_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .rdata_o(pop_entry)
  );

  // Back: multiply, round, saturate and drive the result register.
  adsr_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ENTRY_BITS (EntryBits)
  ) u_adsr_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(queue_valid),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_o     (sample_out),
    .phase_o      (m_axis_tuser),
    .last_o       (m_axis_tlast)
  );

  // Zero-fill tdata up to a whole number of bytes.
  assign m_axis_tdata = TdataBits'(sample_out);

endmodule

@@ src/adsr_checker.sv @@
`include "adsr_envelope_shaper_assert.svh"

module adsr_checker #(
  parameter int unsigned TDATA_BITS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [adsr_pkg::CfgIndexBits-1:0] cfg_index_i,
  input logic [adsr_pkg::CfgDataBits-1:0]  cfg_data_i,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [TDATA_BITS-1:0]             s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [TDATA_BITS-1:0]             m_axis_tdata,
  input logic [adsr_pkg::PhaseBits-1:0]    m_axis_tuser,
  input logic                              m_axis_tlast
);

  // A stalled result stays put.
  `ADSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // Every register write starts a step recompute.
  `ADSR_ASSERT_NEXT(a_cfg_recompute, cfg_valid_i && cfg_ready_o, !cfg_ready_o, "register write did not start step recompute")

  // No sample is taken while the steps are being recomputed.
  `ADSR_ASSERT_SAME(a_no_input_busy, !cfg_ready_o, !s_axis_tready, "sample accepted during step recompute")

endmodule

bind adsr_envelope_shaper adsr_checker #(
  .TDATA_BITS(TdataBits)
) u_adsr_checker (.*);

@@ tb/sv/adsr_envelope_shaper_checker.sv @@
`timescale 1ns / 1ps

module adsr_envelope_shaper_checker #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [adsr_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [adsr_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  input  logic                              s_axis_tready_i,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata_i,   // [SAMPLE_BITS-1:0] sample_in
  input  logic                              m_axis_tvalid_i,
  input  logic                              m_axis_tready_i,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata_i,   // [SAMPLE_BITS-1:0] sample_out
  input  logic [adsr_pkg::PhaseBits-1:0]    m_axis_tuser_i,   // [1:0] phase
  input  logic                              m_axis_tlast_i,   // last_of_sound
  output int                                errors_o,
  output int                                pending_o
);

  localparam int unsigned LevelBits   = adsr_pkg::LevelBits;
  localparam int unsigned LevelFrac   = adsr_pkg::LevelFrac;
  localparam int unsigned GainBits    = adsr_pkg::GainBits;
  localparam int unsigned CfgDataBits = adsr_pkg::CfgDataBits;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    adsr_pkg::phase_e       phase;
    logic                   last;
  } shaped_t;

  localparam longint unsigned LevelMax   = (64'd1 << LevelBits) - 64'd1;
  localparam longint unsigned FracMask   = (64'd1 << LevelFrac) - 64'd1;
  localparam longint unsigned CountMask  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned GainMask   = (64'd1 << GainBits) - 64'd1;
  localparam longint unsigned SampleMask = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam longint unsigned SignBit    = 64'd1 << (SAMPLE_BITS - 1);

  longint unsigned attack_len, decay_len, release_len, sound_len;
  longint unsigned attack_gain, sustain_gain;
  longint unsigned position, level;
  longint unsigned attack_step, decay_step, release_step;
  logic            decay_rises;

  shaped_t shaped_q[$];

  function automatic void derive_steps();
    attack_step = (attack_len != 0) ? (attack_gain << 16) / attack_len : 64'd0;
    decay_rises = sustain_gain > attack_gain;
    if (decay_len == 0) begin
      decay_step = 64'd0;
    end else if (decay_rises) begin
      decay_step = ((sustain_gain - attack_gain) << 16) / decay_len;
    end else begin
      decay_step = ((attack_gain - sustain_gain) << 16) / decay_len;
    end
    release_step = (release_len != 0) ? (sustain_gain << 16) / release_len : 64'd0;
  endfunction

  function automatic void write_register(adsr_pkg::cfg_index_t idx,
                                         logic [CfgDataBits-1:0] data);
    case (idx)
      adsr_pkg::RegAttackSamples:  attack_len   = data & CountMask;
      adsr_pkg::RegDecaySamples:   decay_len    = data & CountMask;
      adsr_pkg::RegReleaseSamples: release_len  = data & CountMask;
      adsr_pkg::RegTotalSamples:   sound_len    = data & CountMask;
      adsr_pkg::RegAttackLevel:    attack_gain  = data & GainMask;
      adsr_pkg::RegSustainLevel:   sustain_gain = data & GainMask;
      default:                     return;
    endcase
    derive_steps();
  endfunction

  // Scale one sample by the current level, then advance the envelope.
  function automatic shaped_t shape_sample(logic [SAMPLE_BITS-1:0] raw);
    shaped_t         want;
    longint unsigned mag, prod, lvl, span;
    logic            neg;
    neg  = raw[SAMPLE_BITS-1];
    mag  = neg ? SampleMask - raw + 64'd1 : raw;
    lvl  = level;
    prod = mag * (lvl >> LevelFrac)
         + ((mag * (lvl & FracMask) + (64'd1 << (LevelFrac - 1))) >> LevelFrac);
    if (neg) begin
      if (prod > SignBit) prod = SignBit;
      prod = (SampleMask + 64'd1 - prod) & SampleMask;
    end else if (prod > SignBit - 64'd1) begin
      prod = SignBit - 64'd1;
    end
    want.sample = prod[SAMPLE_BITS-1:0];

    span = (sound_len != 0) ? sound_len : 64'd1;
    if (position < attack_len) begin
      want.phase = adsr_pkg::PhaseAttack;
      lvl = lvl + attack_step;
      if (lvl > LevelMax) lvl = LevelMax;
    end else if (position < attack_len + decay_len) begin
      want.phase = adsr_pkg::PhaseDecay;
      if (decay_rises) begin
        lvl = lvl + decay_step;
        if (lvl > LevelMax) lvl = LevelMax;
      end else begin
        lvl = (lvl > decay_step) ? lvl - decay_step : 64'd0;
      end
    end else if (position + release_len < span) begin
      want.phase = adsr_pkg::PhaseSustain;
    end else begin
      want.phase = adsr_pkg::PhaseRelease;
      lvl = (lvl > release_step) ? lvl - release_step : 64'd0;
    end

    want.last = (position >= span - 64'd1);
    if (want.last) begin
      position = 64'd0;
      level    = 64'd0;
    end else begin
      position = (position + 64'd1) & CountMask;
      level    = lvl;
    end
    return want;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors_o++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    shaped_t want;
    if (!rst_ni) begin
      attack_len   = 64'd0;
      decay_len    = 64'd0;
      release_len  = 64'd0;
      sound_len    = 64'd1;
      attack_gain  = adsr_pkg::GainResetValue;
      sustain_gain = adsr_pkg::GainResetValue;
      position     = 64'd0;
      level        = 64'd0;
      derive_steps();
      shaped_q.delete();
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (shaped_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_i, 0);
        end else begin
          want = shaped_q.pop_front();
          if (m_axis_tdata_i[SAMPLE_BITS-1:0] !== want.sample)
            report_mismatch("sample_out", m_axis_tdata_i[SAMPLE_BITS-1:0], want.sample);
          if (m_axis_tuser_i !== want.phase)
            report_mismatch("phase", m_axis_tuser_i, want.phase);
          if (m_axis_tlast_i !== want.last)
            report_mismatch("last_of_sound", m_axis_tlast_i, want.last);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        shaped_q.push_back(shape_sample(s_axis_tdata_i[SAMPLE_BITS-1:0]));
      if (cfg_valid_i && cfg_ready_i)
        write_register(cfg_index_i, cfg_data_i);
      pending_o = shaped_q.size();
    end
  end

endmodule

@@ tb/sv/adsr_envelope_shaper_test.sv @@
`timescale 1ns / 1ps

module adsr_envelope_shaper_test;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned CountBits   = 20;
  localparam int unsigned DataBits    = ((SampleBits + 7) / 8) * 8;
  localparam int unsigned GainBits    = adsr_pkg::GainBits;
  localparam int unsigned CfgDataBits = adsr_pkg::CfgDataBits;
  localparam int unsigned PhaseBits   = adsr_pkg::PhaseBits;
  localparam int          CycleLimit  = 200000;
  localparam int          PhaseCount  = 10;
  localparam int          PhaseItems  = 50;
  localparam int          HoldCycles  = 80;
  localparam int          IdlePercent = 9;

  localparam logic [CountBits-1:0]  LenMax    = '1;
  localparam logic [GainBits-1:0]   GainMax   = '1;
  localparam logic [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  // outside the register map; the block must ignore a write here
  localparam adsr_pkg::cfg_index_t RegUnmapped = 3'd7;

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  adsr_pkg::cfg_index_t    cfg_index = adsr_pkg::RegAttackSamples;
  logic [CfgDataBits-1:0]  cfg_data  = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [DataBits-1:0]     s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [DataBits-1:0]     m_tdata;
  logic [PhaseBits-1:0]    m_tuser;
  logic                    m_tlast;

  int errors;
  int pending;
  bit calm      = 1'b0;  // both sides stop idling while set
  int hold_left = 0;     // cycles the result side still has to hold off

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  adsr_envelope_shaper #(
    .SAMPLE_BITS(SampleBits),
    .COUNT_BITS (CountBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  adsr_envelope_shaper_checker #(
    .SAMPLE_BITS(SampleBits),
    .COUNT_BITS (CountBits)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Stop a hung run: count rising edges up to the limit.
  initial begin : watchdog
    int cycle;
    for (cycle = 0; cycle < CycleLimit; cycle++) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: drop tready now and then, or hold it low for a requested
  // stretch, counting the stretch down here one cycle at a time.
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Offer one sample, idling first at random; return at the falling edge after
  // the transfer with tvalid still high, so back-to-back samples need no dip.
  task automatic send_sample(logic [SampleBits-1:0] value);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      s_tdata  <= DataBits'($urandom);
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; bits above the register width carry random noise.
  task automatic write_reg(adsr_pkg::cfg_index_t idx, logic [CfgDataBits-1:0] value);
    logic [CfgDataBits-1:0] noise;
    noise = $urandom;
    cfg_index <= idx;
    if (idx == adsr_pkg::RegAttackLevel || idx == adsr_pkg::RegSustainLevel)
      cfg_data <= {noise[CfgDataBits-1:GainBits], value[GainBits-1:0]};
    else
      cfg_data <= {noise[CfgDataBits-1:CountBits], value[CountBits-1:0]};
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_settings(logic [CountBits-1:0] a_len, logic [CountBits-1:0] d_len,
                                logic [CountBits-1:0] r_len, logic [CountBits-1:0] n_len,
                                logic [GainBits-1:0] peak, logic [GainBits-1:0] hold);
    write_reg(adsr_pkg::RegAttackSamples, a_len);
    write_reg(adsr_pkg::RegDecaySamples, d_len);
    write_reg(adsr_pkg::RegReleaseSamples, r_len);
    write_reg(adsr_pkg::RegTotalSamples, n_len);
    write_reg(adsr_pkg::RegAttackLevel, peak);
    write_reg(adsr_pkg::RegSustainLevel, hold);
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return '0;
      3:       return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // Mostly short durations so whole envelopes run by; now and then an extreme.
  function automatic logic [CountBits-1:0] pick_len(int unsigned short_max);
    case ($urandom_range(11))
      0:       return '0;
      1:       return LenMax;
      2:       return CountBits'($urandom_range(LenMax));
      default: return CountBits'($urandom_range(short_max));
    endcase
  endfunction

  function automatic logic [GainBits-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GainMax;
      2:       return adsr_pkg::GainResetValue;
      default: return GainBits'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int phase_no;
    int k;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: level is zero and each sample closes a one-sample sound.
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample('0);
    drain();

    // One full envelope through all four phases, peak at full scale.
    write_settings(3, 2, 3, 10, GainMax, adsr_pkg::GainResetValue);
    for (k = 0; k < 10; k++) begin
      send_sample((k == 4) ? 16'h0001 : (k == 5) ? '1 : k[0] ? SampleMin : SampleMax);
    end
    drain();

    // Rising decay, re-armed mid-sound by moving the attack end up to the
    // current index, pumps the level into its upper bound.
    write_settings(0, 1, 0, LenMax, '0, GainMax);
    send_sample(SampleMax);
    for (k = 1; k <= 4; k++) begin
      drain();
      write_reg(adsr_pkg::RegAttackSamples, k);
      send_sample(k[0] ? SampleMin : SampleMax);
    end
    // Hold the saturated level in sustain; outputs clip at both ends.
    drain();
    write_reg(adsr_pkg::RegAttackSamples, 0);
    send_sample(SampleMax);
    send_sample(SampleMin);

    // Zero sound length with the index past the end: every sample is last.
    drain();
    write_reg(adsr_pkg::RegTotalSamples, 0);
    write_reg(RegUnmapped, $urandom);
    send_sample(pick_sample());
    send_sample(pick_sample());

    // Random phases, each with fresh settings. Phase 0 takes every maximum,
    // phase 1 every zero, phase 3 runs without idling and phase 5 stalls the
    // result side long enough to back the block up into its input.
    for (phase_no = 0; phase_no < PhaseCount; phase_no++) begin
      drain();
      calm = (phase_no == 3);
      if (phase_no == 0)
        write_settings(LenMax, LenMax, LenMax, LenMax, GainMax, GainMax);
      else if (phase_no == 1)
        write_settings('0, '0, '0, '0, '0, '0);
      else
        write_settings(pick_len(10), pick_len(10), pick_len(10), pick_len(40),
                       pick_gain(), pick_gain());
      for (k = 0; k < PhaseItems; k++) begin
        if (phase_no == 5 && k == 10) hold_left = HoldCycles;
        send_sample(pick_sample());
      end
    end

    drain();
    calm = 1'b0;
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
